// ===== design/sbp_pkg.sv =====
`default_nettype none

package sbp_pkg;

    // Field widths of the report, in bits.
    localparam logic [4:0] SN_BITS  = 5'd18;
    localparam logic [4:0] EXT_BITS = 5'd3;
    localparam logic [4:0] SO_BITS  = 5'd16;
    localparam logic [4:0] RL_BITS  = 5'd8;
    localparam logic [4:0] C_BITS   = 5'd1;
    localparam logic [4:0] NO_BITS  = 5'd0;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned TDATA_BITS = 64;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ACK_SN   = 4'd1,
        PH_ACK_C    = 4'd2,
        PH_NACK_SN  = 4'd3,
        PH_EXT      = 4'd4,
        PH_SO_START = 4'd5,
        PH_SO_END   = 4'd6,
        PH_RANGE    = 4'd7,
        PH_DONE     = 4'd8
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  bits_left;
        logic [17:0] field_shift;
        logic [17:0] held_seq;
        logic [2:0]  held_flags;
        logic [15:0] held_start;
        logic [15:0] held_end;
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [17:0] seq;
        logic        more;
        logic        offs;
        logic        rng;
        logic [15:0] so_start;
        logic [15:0] so_end;
        logic [7:0]  len;
    } t_record;

    typedef struct packed {
        t_state  st;
        logic    emit;
        t_record rec;
    } t_bit_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_IDLE,
        bits_left:   5'd0,
        field_shift: 18'd0,
        held_seq:    18'd0,
        held_flags:  3'd0,
        held_start:  16'd0,
        held_end:    16'd0
    };

    function automatic t_state begin_field(t_state s, t_phase p, logic [4:0] w);
        t_state r;
        r = s;
        r.phase       = p;
        r.bits_left   = w;
        r.field_shift = '0;
        return r;
    endfunction

    // Emits the negative acknowledgement record held in s and moves on
    // to the next record or to the end of the report.
    function automatic t_bit_result finish_nack(t_state s, logic [7:0] len);
        t_bit_result r;
        r.emit         = 1'b1;
        r.rec.kind     = 1'b1;
        r.rec.seq      = s.held_seq;
        r.rec.more     = s.held_flags[2];
        r.rec.offs     = s.held_flags[1];
        r.rec.rng      = s.held_flags[0];
        r.rec.so_start = s.held_start;
        r.rec.so_end   = s.held_end;
        r.rec.len      = len;
        if (s.held_flags[2]) begin
            r.st = begin_field(s, PH_NACK_SN, SN_BITS);
        end else begin
            r.st = begin_field(s, PH_DONE, NO_BITS);
        end
        return r;
    endfunction

    // One bit of the stream through the parser.
    function automatic t_bit_result take_bit(t_state s, logic b);
        t_bit_result r;
        logic [17:0] v;
        logic [4:0]  left;
        r.st   = s;
        r.emit = 1'b0;
        r.rec  = '0;
        v      = {s.field_shift[16:0], b};
        left   = (s.bits_left != 5'd0) ? (s.bits_left - 5'd1) : 5'd0;
        unique case (s.phase)
            PH_ACK_C: begin
                r.emit     = 1'b1;
                r.rec.kind = 1'b0;
                r.rec.seq  = s.held_seq;
                r.rec.more = b;
                if (b) begin
                    r.st = begin_field(s, PH_NACK_SN, SN_BITS);
                end else begin
                    r.st = begin_field(s, PH_DONE, NO_BITS);
                end
            end
            PH_ACK_SN, PH_NACK_SN, PH_EXT, PH_SO_START, PH_SO_END, PH_RANGE: begin
                r.st.field_shift = v;
                r.st.bits_left   = left;
                if (left == 5'd0) begin
                    unique case (s.phase)
                        PH_ACK_SN: begin
                            r.st.held_seq = v;
                            r.st = begin_field(r.st, PH_ACK_C, C_BITS);
                        end
                        PH_NACK_SN: begin
                            r.st.held_seq = v;
                            r.st = begin_field(r.st, PH_EXT, EXT_BITS);
                        end
                        PH_EXT: begin
                            r.st.held_flags = v[2:0];
                            r.st.held_start = '0;
                            r.st.held_end   = '0;
                            if (v[1]) begin
                                r.st = begin_field(r.st, PH_SO_START, SO_BITS);
                            end else if (v[0]) begin
                                r.st = begin_field(r.st, PH_RANGE, RL_BITS);
                            end else begin
                                r = finish_nack(r.st, 8'd0);
                            end
                        end
                        PH_SO_START: begin
                            r.st.held_start = v[15:0];
                            r.st = begin_field(r.st, PH_SO_END, SO_BITS);
                        end
                        PH_SO_END: begin
                            r.st.held_end = v[15:0];
                            if (r.st.held_flags[0]) begin
                                r.st = begin_field(r.st, PH_RANGE, RL_BITS);
                            end else begin
                                r = finish_nack(r.st, 8'd0);
                            end
                        end
                        default: begin
                            r = finish_nack(r.st, v[7:0]);
                        end
                    endcase
                end
            end
            default: begin
                // Idle, done or an unused code: the bit is dropped.
                r.st = s;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sbp_parse.sv =====
`default_nettype none

// Runs the eight bits of one byte through the parser, most significant
// bit first, and returns the state after the byte and the record it closes.
module sbp_parse (
    input  wire  sbp_pkg::t_state  i_state,
    input  wire  logic [7:0]       i_byte,
    input  wire  logic             i_start,
    output sbp_pkg::t_state        o_state,
    output logic                   o_emit,
    output sbp_pkg::t_record       o_rec
);

    sbp_pkg::t_state      chain    [sbp_pkg::BYTE_BITS+1];
    sbp_pkg::t_bit_result step_res [sbp_pkg::BYTE_BITS];

    assign chain[0] = i_start
        ? sbp_pkg::begin_field(sbp_pkg::STATE_RESET, sbp_pkg::PH_ACK_SN, sbp_pkg::SN_BITS)
        : i_state;

    for (genvar k = 0; k < sbp_pkg::BYTE_BITS; k++) begin : g_bit
        assign step_res[k] = sbp_pkg::take_bit(chain[k], i_byte[sbp_pkg::BYTE_BITS-1-k]);
        assign chain[k+1]  = step_res[k].st;
    end

    assign o_state = chain[sbp_pkg::BYTE_BITS];

    // A record is at least 19 bits long, so at most one closes per byte;
    // the earliest one wins regardless.
    always_comb begin
        o_emit = 1'b0;
        o_rec  = '0;
        for (int k = sbp_pkg::BYTE_BITS - 1; k >= 0; k--) begin
            if (step_res[k].emit) begin
                o_emit = 1'b1;
                o_rec  = step_res[k].rec;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/status_report_bit_parser.sv =====
`default_nettype none

// Channel  | Direction | tdata (lowest bit up)                          | tuser        | tlast
// ---------+-----------+------------------------------------------------+--------------+------------
// s (in)   | input     | data_byte[7:0]                                 | report_start | -
// m (out)  | output    | seq_number[17:0], more_follows, has_offsets,   | record_kind  | last_record
//          |           | has_range, offset_start[15:0], offset_end[15:0],|             |
//          |           | range_length[7:0], 3 zero bits                 |              |
//
// One byte is accepted per cycle while the output is not stalled. A byte
// sits in the input register, the eight bit steps of the parser run
// combinationally from there, and a finished record lands in the output
// register when the byte moves on from the input register.
// The synchronous active-low reset returns the parser to idle: bytes are
// ignored until one arrives with report_start set.
// A stall on the output holds the input register; a new byte is still taken
// whenever the byte in the input register can move on in the same cycle.
module status_report_bit_parser (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // Input requests.
    input  wire  logic        i_s_tvalid,
    output logic              o_s_tready,
    input  wire  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  wire  logic        i_s_tuser,   // report_start
    // Parsed records.
    output logic              o_m_tvalid,
    input  wire  logic        i_m_tready,
    output logic [63:0]       o_m_tdata,   // seq_number, more_follows, has_offsets,
                                           // has_range, offset_start, offset_end,
                                           // range_length, zero fill
    output logic              o_m_tuser,   // record_kind
    output logic              o_m_tlast    // last_record
);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    // Parser state, updated once per byte.
    sbp_pkg::t_state  r_state;
    sbp_pkg::t_state  n_state;

    // Output register.
    logic             r_out_valid;
    sbp_pkg::t_record r_out_rec;

    logic             step_emit;
    sbp_pkg::t_record step_rec;
    logic             advance;

    sbp_parse u_parse (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_state (n_state),
        .o_emit  (step_emit),
        .o_rec   (step_rec)
    );

    // The held byte moves on when the output register is empty or drains
    // this cycle; while a record is stalled the byte waits, whether or not
    // it closes a record itself.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= sbp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
        if (advance && step_emit) begin
            r_out_rec <= step_rec;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_rec.len, r_out_rec.so_end, r_out_rec.so_start,
                         r_out_rec.rng, r_out_rec.offs, r_out_rec.more, r_out_rec.seq};
    assign o_m_tuser  = r_out_rec.kind;
    assign o_m_tlast  = ~r_out_rec.more;

endmodule

`default_nettype wire
